FILE: hw/rtl/plb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the pixel layer blend block.
// No dependencies; imported by plb_channel and pixel_layer_blend.
package plb_pkg;

	localparam int ChanW   = 8;
	localparam int AddendW = 9;
	localparam int FactorW = 8;
	localparam int SelectW = 2;
	localparam int ModeW   = 3;
	localparam int CfgIdxW = 2;
	localparam int CfgW    = 9;

	// Reciprocal of 255 scaled by 2^23, rounded up. Exact for dividends below 66052.
	localparam logic [15:0] Recip255 = 16'd32897;
	localparam int RecipShift = 23;

	typedef enum logic [ModeW-1:0] {
		MODE_MULTIPLY = 3'd0,
		MODE_SUBTRACT = 3'd1,
		MODE_SCREEN   = 3'd2,
		MODE_OVERLAY  = 3'd3,
		MODE_ADD      = 3'd4,
		MODE_SCALE    = 3'd5
	} mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ADDEND = 2'd0,
		REG_FACTOR = 2'd1,
		REG_SELECT = 2'd2
	} cfg_reg_t;

	typedef enum logic [SelectW-1:0] {
		SEL_BLUE  = 2'd0,
		SEL_GREEN = 2'd1,
		SEL_RED   = 2'd2,
		SEL_NONE  = 2'd3
	} chan_sel_t;

	// Operation applied to one channel after mode and channel select are resolved.
	typedef enum logic [2:0] {
		OP_MULTIPLY,
		OP_SUBTRACT,
		OP_SCREEN,
		OP_OVERLAY,
		OP_ADD,
		OP_SCALE,
		OP_PASS
	} chan_op_t;

	// How the last stage forms the channel value.
	typedef enum logic [1:0] {
		RES_DIRECT,
		RES_ROUND,
		RES_SAT
	} res_kind_t;

	typedef struct packed {
		chan_op_t                   op;
		logic signed [AddendW-1:0]  addend;
		logic [FactorW-1:0]         factor;
	} chan_ctl_t;

endpackage

FILE: hw/rtl/pixel_layer_blend.sv
`timescale 1ns / 1ps
// Top level of the pixel layer blend: handshake, configuration registers
// and three plb_channel datapaths. Depends on plb_pkg and plb_channel.
//
// Usage: a pixel pair (top layer A, base layer B) and a blend mode enter on
// the input channel (in_valid / in_stall); one blended pixel leaves on the
// output channel (out_valid / out_stall) for every input transfer, in order.
// Modes 0 to 3 blend each color channel (multiply, subtract, screen,
// overlay). Modes 4 and 5 add the configured addend to, or scale by the
// configured factor, the channel picked by channel_select, clamped to
// 0..255; other channels and unused mode codes pass B through.
//
// Pipeline: operands, product, reciprocal multiply for the divide by 255
// and output register. Throughput is one pixel per cycle while the output
// is not stalled. When the output holds a pixel and out_stall is
// high, every stage holds and in_stall is raised, so nothing is dropped or
// repeated; the input is held then even if earlier stages are empty.
//
// Reset (arst_n low) clears all valid bits and sets addend 0, factor 1 and
// channel select blue. Configuration writes (cfg_we, cfg_index, cfg_data)
// take effect at once and must be made while no pixel is in flight.
module pixel_layer_blend
	import plb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic [ModeW-1:0]   mode,
	input  logic [ChanW-1:0]   top_red,
	input  logic [ChanW-1:0]   top_green,
	input  logic [ChanW-1:0]   top_blue,
	input  logic [ChanW-1:0]   base_red,
	input  logic [ChanW-1:0]   base_green,
	input  logic [ChanW-1:0]   base_blue,

	output logic               out_valid,
	input  logic               out_stall,
	output logic [ChanW-1:0]   out_red,
	output logic [ChanW-1:0]   out_green,
	output logic [ChanW-1:0]   out_blue
);

	logic signed [AddendW-1:0] addend_q;
	logic [FactorW-1:0]        factor_q;
	chan_sel_t                 select_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic advance;

	chan_op_t  blend_op;
	chan_op_t  adjust_op;
	chan_ctl_t ctl_red, ctl_green, ctl_blue;

	// Configuration registers. A write to an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addend_q <= '0;
			factor_q <= FactorW'(1);
			select_q <= SEL_BLUE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ADDEND: addend_q <= cfg_data[AddendW-1:0];
				REG_FACTOR: factor_q <= cfg_data[FactorW-1:0];
				REG_SELECT: select_q <= chan_sel_t'(cfg_data[SelectW-1:0]);
				default:    ;
			endcase
		end
	end

	// The whole pipeline advances unless the output register holds a pixel
	// that the receiver is not taking this cycle.
	assign advance   = !valid_s4 || !out_stall;
	assign in_stall  = !advance;
	assign out_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Resolve the mode into a per-channel operation. Blend modes apply to all
	// three channels; adjust modes touch only the selected channel.
	always_comb begin
		blend_op  = OP_PASS;
		adjust_op = OP_PASS;
		case (mode)
			MODE_MULTIPLY: blend_op  = OP_MULTIPLY;
			MODE_SUBTRACT: blend_op  = OP_SUBTRACT;
			MODE_SCREEN:   blend_op  = OP_SCREEN;
			MODE_OVERLAY:  blend_op  = OP_OVERLAY;
			MODE_ADD:      adjust_op = OP_ADD;
			MODE_SCALE:    adjust_op = OP_SCALE;
			default:       blend_op  = OP_PASS;
		endcase

		ctl_red.addend   = addend_q;
		ctl_red.factor   = factor_q;
		ctl_green.addend = addend_q;
		ctl_green.factor = factor_q;
		ctl_blue.addend  = addend_q;
		ctl_blue.factor  = factor_q;
		ctl_red.op       = blend_op;
		ctl_green.op     = blend_op;
		ctl_blue.op      = blend_op;
		case (select_q)
			SEL_RED:   if (adjust_op != OP_PASS) ctl_red.op   = adjust_op;
			SEL_GREEN: if (adjust_op != OP_PASS) ctl_green.op = adjust_op;
			SEL_BLUE:  if (adjust_op != OP_PASS) ctl_blue.op  = adjust_op;
			default:   ;
		endcase
	end

	plb_channel u_red (
		.clk     (clk),
		.en      (advance),
		.ctl     (ctl_red),
		.top_px  (top_red),
		.base_px (base_red),
		.result  (out_red)
	);

	plb_channel u_green (
		.clk     (clk),
		.en      (advance),
		.ctl     (ctl_green),
		.top_px  (top_green),
		.base_px (base_green),
		.result  (out_green)
	);

	plb_channel u_blue (
		.clk     (clk),
		.en      (advance),
		.ctl     (ctl_blue),
		.top_px  (top_blue),
		.base_px (base_blue),
		.result  (out_blue)
	);

endmodule

FILE: hw/rtl/plb_channel.sv
`timescale 1ns / 1ps
// Four-stage datapath for one color channel of the layer blend.
// Depends on plb_pkg.
module plb_channel
	import plb_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  chan_ctl_t         ctl,
	input  logic [ChanW-1:0]  top_px,
	input  logic [ChanW-1:0]  base_px,
	output logic [ChanW-1:0]  result
);

	// Stage 1: operands
	res_kind_t         kind_d;
	logic              inv_d;
	logic [ChanW:0]    x_d;
	logic [ChanW-1:0]  y_d;
	logic [ChanW-1:0]  direct_d;
	logic signed [ChanW+1:0] sum_d;

	res_kind_t         kind_s1, kind_s2, kind_s3;
	logic              inv_s1, inv_s2, inv_s3;
	logic [ChanW:0]    x_s1;
	logic [ChanW-1:0]  y_s1;
	logic [ChanW-1:0]  direct_s1, direct_s2, direct_s3;

	// Stage 2: product
	logic [2*ChanW:0]  prod_s2;

	// Stage 3: rounded quotient and saturation
	logic [2*ChanW+1:0]    biased;
	logic [2*ChanW+17:0]   recip_prod;
	logic [ChanW-1:0]      quot_s3;
	logic                  sat_s3;
	logic [ChanW-1:0]      low_s3;

	always_comb begin
		kind_d   = RES_DIRECT;
		inv_d    = 1'b0;
		x_d      = {1'b0, top_px};
		y_d      = base_px;
		direct_d = base_px;
		sum_d    = $signed({2'b00, base_px}) + (ChanW+2)'(ctl.addend);
		case (ctl.op)
			OP_MULTIPLY: begin
				kind_d = RES_ROUND;
			end
			OP_SCREEN: begin
				kind_d = RES_ROUND;
				inv_d  = 1'b1;
				x_d    = {1'b0, ~top_px};
				y_d    = ~base_px;
			end
			OP_OVERLAY: begin
				kind_d = RES_ROUND;
				// Dark base doubles the multiply; light base doubles the screen.
				if (!base_px[ChanW-1]) begin
					x_d = {top_px, 1'b0};
				end else begin
					inv_d = 1'b1;
					x_d   = {~top_px, 1'b0};
					y_d   = ~base_px;
				end
			end
			OP_SUBTRACT: begin
				direct_d = (base_px > top_px) ? (base_px - top_px) : '0;
			end
			OP_ADD: begin
				if (sum_d < 0)
					direct_d = '0;
				else if (sum_d > $signed((ChanW+2)'(255)))
					direct_d = '1;
				else
					direct_d = sum_d[ChanW-1:0];
			end
			OP_SCALE: begin
				kind_d = RES_SAT;
				x_d    = {1'b0, ctl.factor};
			end
			default: begin
				direct_d = base_px;
			end
		endcase
	end

	assign biased     = {1'b0, prod_s2} + (2*ChanW+2)'(127);
	assign recip_prod = biased * Recip255;

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1   <= kind_d;
			inv_s1    <= inv_d;
			x_s1      <= x_d;
			y_s1      <= y_d;
			direct_s1 <= direct_d;

			kind_s2   <= kind_s1;
			inv_s2    <= inv_s1;
			direct_s2 <= direct_s1;
			prod_s2   <= x_s1 * y_s1;

			kind_s3   <= kind_s2;
			inv_s3    <= inv_s2;
			direct_s3 <= direct_s2;
			quot_s3   <= recip_prod[RecipShift+ChanW-1:RecipShift];
			sat_s3    <= |prod_s2[2*ChanW:ChanW];
			low_s3    <= prod_s2[ChanW-1:0];

			case (kind_s3)
				RES_ROUND: result <= inv_s3 ? ~quot_s3 : quot_s3;
				RES_SAT:   result <= sat_s3 ? '1 : low_s3;
				default:   result <= direct_s3;
			endcase
		end
	end

endmodule
